// File: rtl/ssgu_pkg.sv
// Package for the stochastic SIR grid update block.
// Holds the controller state type, the command codes, the cell codes and the
// configuration register indexes and reset values. No dependencies.
package ssgu_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPD
    } t_state;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_COMMIT = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    localparam logic [1:0] CELL_SUS = 2'd0;
    localparam logic [1:0] CELL_INF = 2'd1;
    localparam logic [1:0] CELL_REM = 2'd2;

    localparam logic [1:0] CFG_ROWS    = 2'd0;
    localparam logic [1:0] CFG_COLS    = 2'd1;
    localparam logic [1:0] CFG_INFECT  = 2'd2;
    localparam logic [1:0] CFG_RECOVER = 2'd3;

    localparam logic [5:0]  RST_ROWS    = 6'd20;
    localparam logic [5:0]  RST_COLS    = 6'd20;
    localparam logic [15:0] RST_INFECT  = 16'd19661;
    localparam logic [15:0] RST_RECOVER = 16'd3277;

endpackage

// File: rtl/ssgu_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; width and depth come from parameters.
module ssgu_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/stochastic_sir_grid_update.sv
// Top level of the stochastic SIR grid update block.
// Depends on ssgu_pkg and two instances of ssgu_ram (bank a and bank b).
//
// A command is taken when start is high and busy is low. Write and commit are done
// in ST_IDLE, a read passes through ST_READ, and an update through ST_UPD: the cell
// and its four neighbors are fetched one after another through the single read port
// of the current bank, and the new value is written to the next bank in the last
// update step. Each command gives one result, shown for exactly one cycle with
// o_done high; the receiver cannot stall it, so it must take every result. After
// reset the block clears both banks, one cell per cycle, and stays busy until every
// cell is cleared; configuration writes are taken at any time.
module stochastic_sir_grid_update
    import ssgu_pkg::*;
#(
    parameter int MAX_ROWS  = 32,
    parameter int MAX_COLS  = 32,
    parameter int DRAW_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_mode,
    input  logic [4:0]           i_row,
    input  logic [4:0]           i_column,
    input  logic [1:0]           i_cell_value,
    input  logic [DRAW_BITS-1:0] i_draw_zero,
    input  logic [DRAW_BITS-1:0] i_draw_one,
    input  logic [DRAW_BITS-1:0] i_draw_two,
    input  logic [DRAW_BITS-1:0] i_draw_three,
    output logic                 o_done,
    output logic [1:0]           o_cell_state,
    output logic [2:0]           o_infected_neighbours,
    output logic                 o_changed,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SH_UP = (DRAW_BITS >= 16) ? DRAW_BITS - 16 : 0;
    localparam int SH_DN = (DRAW_BITS < 16) ? 16 - DRAW_BITS : 0;

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] row, input logic [5:0] col);
        cell_addr = AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    function automatic logic [DRAW_BITS-1:0] scale_prob(input logic [15:0] prob);
        logic [DRAW_BITS+15:0] wide;
        wide = ({{DRAW_BITS{1'b0}}, prob} << SH_UP) >> SH_DN;
        scale_prob = wide[DRAW_BITS-1:0];
    endfunction

    // Configuration registers
    logic [5:0]  r_rows, r_cols;
    logic [15:0] r_infect, r_recover;

    // Control state
    t_state      r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic        r_bank, n_bank;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_done, n_done;

    // Result and command payload
    logic [1:0]  r_cell, n_cell;
    logic [2:0]  r_count, n_count;
    logic        r_chg, n_chg;
    logic [4:0]  r_row, r_col;
    logic [DRAW_BITS-1:0] r_draw0, r_draw1, r_draw2, r_draw3;
    logic [1:0]  r_center;
    logic [2:0]  r_inf;

    // Memory ports
    logic          we_a, we_b;
    logic [AW-1:0] waddr, raddr;
    logic [1:0]    wdata;
    logic [1:0]    rdata_a, rdata_b, cur_rdata;

    logic          accept;
    logic          in_row_ok, in_col_ok, in_inside;
    logic [AW-1:0] in_addr;
    logic [1:0]    in_value;
    logic [9:0]    row_p1, col_p1;
    logic          up_ok, dn_ok, lf_ok, rt_ok;
    logic [5:0]    row6, col6, row_up, row_dn, col_lf, col_rt;
    logic [DRAW_BITS-1:0] thr_inf, thr_rec;
    logic [3:0]    inf_flags;
    logic [2:0]    inf_count;
    logic          hit_inf, hit_rec;
    logic [1:0]    new_value;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= RST_ROWS;
            r_cols    <= RST_COLS;
            r_infect  <= RST_INFECT;
            r_recover <= RST_RECOVER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS:    r_rows    <= i_cfg_data[5:0];
                CFG_COLS:    r_cols    <= i_cfg_data[5:0];
                CFG_INFECT:  r_infect  <= i_cfg_data;
                CFG_RECOVER: r_recover <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A size register of zero behaves as one row or column.
    assign in_row_ok = (r_rows == 6'd0) ? (i_row == 5'd0)
                     : ((10'(i_row) < 10'(r_rows)) && (10'(i_row) < 10'(MAX_ROWS)));
    assign in_col_ok = (r_cols == 6'd0) ? (i_column == 5'd0)
                     : ((10'(i_column) < 10'(r_cols)) && (10'(i_column) < 10'(MAX_COLS)));
    assign in_inside = in_row_ok && in_col_ok;
    assign in_addr   = cell_addr({1'b0, i_row}, {1'b0, i_column});
    assign in_value  = (i_cell_value > CELL_REM) ? CELL_REM : i_cell_value;

    // Neighbor positions of the latched cell; a missing neighbor reads the cell itself.
    assign row6   = {1'b0, r_row};
    assign col6   = {1'b0, r_col};
    assign row_p1 = 10'(r_row) + 10'd1;
    assign col_p1 = 10'(r_col) + 10'd1;
    assign up_ok  = (r_row != 5'd0);
    assign dn_ok  = (row_p1 < 10'(r_rows)) && (row_p1 < 10'(MAX_ROWS));
    assign lf_ok  = (r_col != 5'd0);
    assign rt_ok  = (col_p1 < 10'(r_cols)) && (col_p1 < 10'(MAX_COLS));
    assign row_up = up_ok ? row6 - 6'd1 : row6;
    assign row_dn = dn_ok ? row6 + 6'd1 : row6;
    assign col_lf = lf_ok ? col6 - 6'd1 : col6;
    assign col_rt = rt_ok ? col6 + 6'd1 : col6;

    assign cur_rdata = r_bank ? rdata_b : rdata_a;

    // Evaluation in the last update cycle, when the right neighbor is on the read port.
    assign thr_inf   = scale_prob(r_infect);
    assign thr_rec   = scale_prob(r_recover);
    assign inf_flags = {rt_ok && (cur_rdata == CELL_INF), r_inf};
    assign inf_count = {2'b0, inf_flags[0]} + {2'b0, inf_flags[1]}
                     + {2'b0, inf_flags[2]} + {2'b0, inf_flags[3]};
    assign hit_inf   = ((inf_count > 3'd0) && (r_draw0 < thr_inf))
                    || ((inf_count > 3'd1) && (r_draw1 < thr_inf))
                    || ((inf_count > 3'd2) && (r_draw2 < thr_inf))
                    || ((inf_count > 3'd3) && (r_draw3 < thr_inf));
    assign hit_rec   = (r_draw0 < thr_rec);

    always_comb begin
        if (r_center == CELL_SUS) begin
            new_value = hit_inf ? CELL_INF : CELL_SUS;
        end else if (r_center == CELL_INF) begin
            new_value = hit_rec ? CELL_REM : CELL_INF;
        end else begin
            new_value = r_center;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bank  = r_bank;
        n_clr   = r_clr;
        n_done  = 1'b0;
        n_cell  = r_cell;
        n_count = r_count;
        n_chg   = r_chg;
        we_a    = 1'b0;
        we_b    = 1'b0;
        waddr   = cell_addr(row6, col6);
        wdata   = CELL_SUS;
        raddr   = cell_addr(row6, col6);
        case (r_state)
            ST_CLEAR: begin
                we_a  = 1'b1;
                we_b  = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                raddr = in_addr;
                if (accept) begin
                    n_cell  = CELL_SUS;
                    n_count = 3'd0;
                    n_chg   = 1'b0;
                    case (t_mode'(i_mode))
                        MODE_COMMIT: begin
                            n_bank = ~r_bank;
                            n_done = 1'b1;
                        end
                        MODE_WRITE: begin
                            n_done = 1'b1;
                            if (in_inside) begin
                                we_a   = 1'b1;
                                we_b   = 1'b1;
                                waddr  = in_addr;
                                wdata  = in_value;
                                n_cell = in_value;
                            end
                        end
                        MODE_READ: begin
                            if (in_inside) begin
                                n_state = ST_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        MODE_UPDATE: begin
                            if (in_inside) begin
                                n_state = ST_UPD;
                                n_step  = 3'd0;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_cell  = cur_rdata;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_UPD: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: raddr = cell_addr(row_up, col6);
                    3'd1: raddr = cell_addr(row_dn, col6);
                    3'd2: raddr = cell_addr(row6, col_lf);
                    3'd3: raddr = cell_addr(row6, col_rt);
                    default: begin
                        // The next bank is the one that is not current.
                        we_a    = r_bank;
                        we_b    = ~r_bank;
                        wdata   = new_value;
                        n_cell  = new_value;
                        n_count = (r_center == CELL_SUS) ? inf_count : 3'd0;
                        n_chg   = (new_value != r_center);
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step  <= 3'd0;
            r_bank  <= 1'b0;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bank  <= n_bank;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell  <= n_cell;
        r_count <= n_count;
        r_chg   <= n_chg;
        if (accept) begin
            r_row   <= i_row;
            r_col   <= i_column;
            r_draw0 <= i_draw_zero;
            r_draw1 <= i_draw_one;
            r_draw2 <= i_draw_two;
            r_draw3 <= i_draw_three;
        end
        if (r_state == ST_UPD) begin
            case (r_step)
                3'd0: r_center <= cur_rdata;
                3'd1: r_inf[0] <= up_ok && (cur_rdata == CELL_INF);
                3'd2: r_inf[1] <= dn_ok && (cur_rdata == CELL_INF);
                3'd3: r_inf[2] <= lf_ok && (cur_rdata == CELL_INF);
                default: ;
            endcase
        end
    end

    ssgu_ram #(
        .WIDTH(2),
        .DEPTH(DEPTH)
    ) u_bank_a (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_a)
    );

    ssgu_ram #(
        .WIDTH(2),
        .DEPTH(DEPTH)
    ) u_bank_b (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_b)
    );

    assign o_done                = r_done;
    assign o_cell_state          = r_cell;
    assign o_infected_neighbours = r_count;
    assign o_changed             = r_chg;

endmodule
